FILE: rtl/serial_eeprom_bit_protocol_assert.svh
// Assertion macros for the serial EEPROM bit protocol block.
// Included by the top level; no other dependencies.
`ifndef SERIAL_EEPROM_BIT_PROTOCOL_ASSERT_SVH
`define SERIAL_EEPROM_BIT_PROTOCOL_ASSERT_SVH
`ifndef SYNTH
`define SEBP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sebp assertion failed");
`define SEBP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sebp assertion failed");
`else
`define SEBP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SEBP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sebp_pkg.sv
// Shared types and constants for the serial EEPROM bit protocol block.
// No dependencies.
`timescale 1ns / 1ps

package sebp_pkg;

  localparam int unsigned STORE_WORDS_DEF = 1024;

  localparam logic [3:0]  ADDR_LEN_SMALL = 4'd6;
  localparam logic [3:0]  ADDR_LEN_LARGE = 4'd14;
  localparam logic [13:0] ADDR_MASK_SMALL = 14'h003F;
  localparam logic [13:0] ADDR_MASK_LARGE = 14'h03FF;
  localparam logic [6:0]  WORD_BITS = 7'd64;
  localparam logic [6:0]  READ_PAD_BITS = 7'd4;
  localparam logic [6:0]  READ_TOTAL_BITS = 7'd68;
  localparam logic [23:0] BUSY_CYCLES_RESET = 24'd108368;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_DESEL = 2'd2,
    REQ_RSVD  = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_SIZE_MODE   = 1'b0,
    CFG_BUSY_CYCLES = 1'b1
  } cfg_idx_e;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_CMD    = 8'b0000_0010,
    PH_RADDR  = 8'b0000_0100,
    PH_WADDR  = 8'b0000_1000,
    PH_RDUMMY = 8'b0001_0000,
    PH_RDATA  = 8'b0010_0000,
    PH_WDATA  = 8'b0100_0000,
    PH_WDUMMY = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    req_type_e   req_type;
    logic        bit_in;
    logic        abort;
    logic [63:0] timestamp;
  } req_t;

  typedef struct packed {
    logic        read_value;
    logic        write_done;
    logic [12:0] changed_offset;
    logic        ready_res;
    logic        active;
  } res_t;

endpackage

FILE: rtl/sebp_store.sv
// Save store of the serial EEPROM: one write port, one registered read port,
// and a zeroing sweep after reset. Depends on nothing but its parameter.
`timescale 1ns / 1ps

module sebp_store #(
  parameter int unsigned STORE_WORDS = 1024,
  localparam int unsigned IdxW = $clog2(STORE_WORDS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [63:0]     wr_data_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [63:0]     rd_data_o,
  output logic            clearing_o
);

  logic [63:0]     mem [STORE_WORDS];
  logic [IdxW-1:0] sweep_q, sweep_d;
  logic            clearing_q, clearing_d;
  logic [63:0]     rd_data_q;
  logic            we;
  logic [IdxW-1:0] widx;
  logic [63:0]     wdata;

  always_comb begin
    sweep_d    = sweep_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (sweep_q == IdxW'(STORE_WORDS - 1)) begin
        clearing_d = 1'b0;
      end else begin
        sweep_d = sweep_q + 1'b1;
      end
    end
  end

  // The sweep owns the write port until every word has been zeroed.
  assign we    = clearing_q | wr_en_i;
  assign widx  = clearing_q ? sweep_q : wr_idx_i;
  assign wdata = clearing_q ? 64'd0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= '0;
      clearing_q <= 1'b1;
    end else begin
      sweep_q    <= sweep_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[widx] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_idx_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

FILE: rtl/serial_eeprom_bit_protocol.sv
// Top level of the bit-serial cartridge EEPROM protocol engine.
// Depends on sebp_pkg, sebp_store and the assertion macro header.
`timescale 1ns / 1ps
`include "serial_eeprom_bit_protocol_assert.svh"

// Usage:
// Each bus clock of the cartridge is one input beat on req_i: a read clock,
// a write clock or a deselect, with the current bus timestamp. A beat is
// taken on a rising edge where start_i is high and busy_o is low.
// Every beat gives exactly one result beat on res_o, marked by done_o for
// one cycle, once it has passed from the input register into the result
// register. The receiver cannot stall; results are simply presented.
// While busy_o is low a new beat may be taken in every cycle, so the sustained
// rate is one beat per clock; each beat is handled by one pass of logic between
// the input register and the result register, and the save store is a single
// memory with one write and one registered read port.
// After reset busy_o stays high while the store is swept to zero; configuration
// writes on cfg_we_i/cfg_idx_i/cfg_wdata_i are taken at any time, the protocol
// is idle, and the busy window is closed.
module serial_eeprom_bit_protocol
  import sebp_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  req_t     req_i,
  output logic     done_o,
  output res_t     res_o,
  input  logic     cfg_we_i,
  input  cfg_idx_e cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(STORE_WORDS);

  // Configuration.
  logic        size_mode_q;
  logic [23:0] busy_cycles_q;

  // Input register.
  logic in_vld_q;
  req_t in_q;

  // Protocol state.
  phase_e          phase_q, phase_d;
  logic [3:0]      addr_len_q, addr_len_d;
  logic [6:0]      bit_cnt_q, bit_cnt_d;
  logic [13:0]     waddr_q, waddr_d;
  logic [IdxW-1:0] sidx_q, sidx_d;
  logic [63:0]     shift_q, shift_d;
  logic [63:0]     busy_end_q, busy_end_d;

  // Result register.
  logic done_q;
  res_t res_q, res_d;

  // Working signals.
  logic            clearing;
  logic [63:0]     rd_data;
  logic            ready_now;
  logic [64:0]     end_sum;
  logic [3:0]      want_len;
  logic            size_bad;
  logic            clr_proto;
  logic            commit;
  logic [6:0]      cnt_inc;
  logic [5:0]      bsel;
  logic [IdxW:0]   idx_step;
  logic            idx_take;
  logic [13:0]     waddr_shift;

  assign busy_o = clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_mode_q   <= 1'b0;
      busy_cycles_q <= BUSY_CYCLES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE_MODE:   size_mode_q   <= cfg_wdata_i[0];
        CFG_BUSY_CYCLES: busy_cycles_q <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= req_i;
    end
  end

  assign ready_now   = (in_q.timestamp >= busy_end_q);
  assign end_sum     = {1'b0, in_q.timestamp} + {41'd0, busy_cycles_q};
  assign want_len    = size_mode_q ? ADDR_LEN_LARGE : ADDR_LEN_SMALL;
  assign size_bad    = (phase_q != PH_IDLE) && (addr_len_q != want_len);
  assign cnt_inc     = bit_cnt_q + 7'd1;
  assign bsel        = 6'(bit_cnt_q - READ_PAD_BITS);
  assign waddr_shift = {waddr_q[12:0], in_q.bit_in};

  // The store index is the address modulo the store depth, built one bit at a
  // time. On the large chip the four top address bits are dropped.
  assign idx_take = !(size_mode_q && (bit_cnt_q < READ_PAD_BITS));
  always_comb begin
    idx_step = {sidx_q, in_q.bit_in};
    if (idx_step >= (IdxW + 1)'(STORE_WORDS)) begin
      idx_step = idx_step - (IdxW + 1)'(STORE_WORDS);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    addr_len_d = addr_len_q;
    bit_cnt_d  = bit_cnt_q;
    waddr_d    = waddr_q;
    sidx_d     = sidx_q;
    shift_d    = shift_q;
    busy_end_d = busy_end_q;
    clr_proto  = 1'b0;
    commit     = 1'b0;
    res_d      = '0;
    res_d.read_value = 1'b1;

    if (in_vld_q) begin
      case (in_q.req_type)
        REQ_READ: begin
          if (!ready_now) begin
            res_d.read_value = 1'b0;
          end else begin
            busy_end_d = '0;
            if (size_bad) begin
              clr_proto = 1'b1;
            end else if (phase_q == PH_RDATA) begin
              res_d.read_value = (bit_cnt_q >= READ_PAD_BITS) ? rd_data[~bsel] : 1'b0;
              bit_cnt_d = cnt_inc;
              if (cnt_inc >= READ_TOTAL_BITS) begin
                clr_proto = 1'b1;
              end
            end
          end
        end
        REQ_WRITE: begin
          if (ready_now) begin
            busy_end_d = '0;
            if (size_bad) begin
              clr_proto = 1'b1;
            end else begin
              case (phase_q)
                PH_IDLE: begin
                  if (in_q.bit_in) begin
                    addr_len_d = want_len;
                    phase_d    = PH_CMD;
                  end
                end
                PH_CMD: begin
                  phase_d = in_q.bit_in ? PH_RADDR : PH_WADDR;
                end
                PH_RADDR, PH_WADDR: begin
                  waddr_d   = waddr_shift;
                  bit_cnt_d = cnt_inc;
                  if (idx_take) begin
                    sidx_d = idx_step[IdxW-1:0];
                  end
                  if (cnt_inc >= {3'd0, addr_len_q}) begin
                    waddr_d   = waddr_shift &
                                (size_mode_q ? ADDR_MASK_LARGE : ADDR_MASK_SMALL);
                    bit_cnt_d = '0;
                    phase_d   = (phase_q == PH_RADDR) ? PH_RDUMMY : PH_WDATA;
                  end
                end
                PH_RDUMMY: begin
                  phase_d = PH_RDATA;
                end
                PH_WDATA: begin
                  shift_d   = {shift_q[62:0], in_q.bit_in};
                  bit_cnt_d = cnt_inc;
                  if (cnt_inc >= WORD_BITS) begin
                    bit_cnt_d = '0;
                    phase_d   = PH_WDUMMY;
                  end
                end
                PH_WDUMMY: begin
                  clr_proto = 1'b1;
                  // A busy window that would run past the timestamp range
                  // abandons the write.
                  if (!end_sum[64]) begin
                    commit               = 1'b1;
                    busy_end_d           = end_sum[63:0];
                    res_d.write_done     = 1'b1;
                    res_d.changed_offset = {waddr_q[9:0], 3'b000};
                  end
                end
                default: ;
              endcase
            end
          end
        end
        REQ_DESEL: begin
          if (in_q.abort || (phase_q != PH_RDATA) || (bit_cnt_q != 7'd0)) begin
            clr_proto = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (clr_proto) begin
      phase_d    = PH_IDLE;
      addr_len_d = '0;
      bit_cnt_d  = '0;
      waddr_d    = '0;
      sidx_d     = '0;
      shift_d    = '0;
    end

    res_d.ready_res = commit ? (busy_cycles_q == 24'd0) : ready_now;
    res_d.active    = (phase_d != PH_IDLE) || !res_d.ready_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      addr_len_q <= '0;
      bit_cnt_q  <= '0;
      waddr_q    <= '0;
      sidx_q     <= '0;
      shift_q    <= '0;
      busy_end_q <= '0;
      done_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      addr_len_q <= addr_len_d;
      bit_cnt_q  <= bit_cnt_d;
      waddr_q    <= waddr_d;
      sidx_q     <= sidx_d;
      shift_q    <= shift_d;
      busy_end_q <= busy_end_d;
      done_q     <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // The read port follows the store index continuously; the index is final
  // well before the first data bit of a read is clocked out.
  sebp_store #(
    .STORE_WORDS(STORE_WORDS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (commit),
    .wr_idx_i   (sidx_q),
    .wr_data_i  (shift_q),
    .rd_idx_i   (sidx_q),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  `SEBP_ASSERT_NXT(a_beat_gives_result, clk_i, rst_ni, in_vld_q, done_o)
  `SEBP_ASSERT_IMP(a_result_has_beat, clk_i, rst_ni, done_o, $past(in_vld_q))
  `SEBP_ASSERT_IMP(a_no_result_in_sweep, clk_i, rst_ni, busy_o, !done_o)
  `SEBP_ASSERT_IMP(a_offset_only_on_commit, clk_i, rst_ni, done_o && !res_o.write_done, res_o.changed_offset == 13'd0)

endmodule

FILE: test/serial_eeprom_checker.sv
`timescale 1ns / 1ps
// Checker for the serial EEPROM bit protocol block: follows every accepted bus beat,
// predicts the reply beat and compares it with the result port field by field.
// Depends on sebp_pkg only.
module serial_eeprom_checker
  import sebp_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  res_t        res_i,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  output int          errors_o,
  output int          pending_o,
  output int          replies_o,
  output int          commits_o
);

  // Chip settings as last written.
  logic        size_large;
  logic [23:0] busy_len;

  // Protocol engine and save memory of the chip.
  phase_e      xfer_phase;
  logic [3:0]  addr_bits;
  logic [6:0]  bit_cnt;
  logic [13:0] word_addr;
  logic [63:0] shift_word;
  logic [63:0] busy_end;
  logic [63:0] save_mem [STORE_WORDS];

  res_t        reply_q [$];
  int          err_cnt;
  int          reply_cnt;
  int          commit_cnt;

  function automatic void drop_transfer();
    xfer_phase = PH_IDLE;
    addr_bits  = '0;
    bit_cnt    = '0;
    word_addr  = '0;
    shift_word = '0;
  endfunction

  function automatic logic [3:0] wanted_bits();
    return size_large ? ADDR_LEN_LARGE : ADDR_LEN_SMALL;
  endfunction

  // A transfer begun under the other chip size is thrown away.
  function automatic logic size_still_fits();
    if (xfer_phase != PH_IDLE && addr_bits != wanted_bits()) begin
      drop_transfer();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic read_clock(input logic [63:0] ts);
    logic [5:0] pos;
    logic       rd_bit;
    if (ts < busy_end) return 1'b0;
    busy_end = '0;
    if (!size_still_fits() || xfer_phase != PH_RDATA) return 1'b1;
    rd_bit = 1'b0;
    if (bit_cnt >= READ_PAD_BITS) begin
      pos    = 6'(bit_cnt - READ_PAD_BITS);
      rd_bit = save_mem[word_addr % STORE_WORDS][63 - pos];
    end
    bit_cnt++;
    if (bit_cnt >= READ_TOTAL_BITS) drop_transfer();
    return rd_bit;
  endfunction

  function automatic logic write_clock(input logic wr_bit, input logic [63:0] ts,
                                       output logic [12:0] offset);
    offset = '0;
    if (ts < busy_end) return 1'b0;
    busy_end = '0;
    if (!size_still_fits()) return 1'b0;
    case (xfer_phase)
      PH_IDLE: begin
        if (wr_bit) begin
          addr_bits  = wanted_bits();
          xfer_phase = PH_CMD;
        end
      end
      PH_CMD: xfer_phase = wr_bit ? PH_RADDR : PH_WADDR;
      PH_RADDR, PH_WADDR: begin
        word_addr = {word_addr[12:0], wr_bit};
        bit_cnt++;
        if (bit_cnt >= 7'(addr_bits)) begin
          word_addr  = word_addr & (size_large ? ADDR_MASK_LARGE : ADDR_MASK_SMALL);
          bit_cnt    = '0;
          xfer_phase = (xfer_phase == PH_RADDR) ? PH_RDUMMY : PH_WDATA;
        end
      end
      PH_RDUMMY: xfer_phase = PH_RDATA;
      PH_WDATA: begin
        shift_word = {shift_word[62:0], wr_bit};
        bit_cnt++;
        if (bit_cnt >= WORD_BITS) begin
          bit_cnt    = '0;
          xfer_phase = PH_WDUMMY;
        end
      end
      PH_WDUMMY: begin
        // The busy window must fit below the top of the bus count.
        if (ts > ~64'd0 - 64'(busy_len)) begin
          drop_transfer();
          return 1'b0;
        end
        offset = {word_addr[9:0], 3'b000};
        save_mem[word_addr % STORE_WORDS] = shift_word;
        busy_end = ts + 64'(busy_len);
        drop_transfer();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic res_t chip_step(input req_t beat);
    res_t       reply;
    logic [12:0] offset;
    reply = '0;
    reply.read_value = 1'b1;
    case (beat.req_type)
      REQ_READ:  reply.read_value = read_clock(beat.timestamp);
      REQ_WRITE: begin
        reply.write_done     = write_clock(beat.bit_in, beat.timestamp, offset);
        reply.changed_offset = offset;
        if (reply.write_done) commit_cnt++;
      end
      REQ_DESEL: begin
        if (beat.abort || xfer_phase != PH_RDATA || bit_cnt != 0) drop_transfer();
      end
      default: ;
    endcase
    reply.ready_res = (beat.timestamp >= busy_end);
    reply.active    = (xfer_phase != PH_IDLE) || !reply.ready_res;
    return reply;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      size_large = 1'b0;
      busy_len   = BUSY_CYCLES_RESET;
      busy_end   = '0;
      drop_transfer();
      for (int i = 0; i < STORE_WORDS; i++) save_mem[i] = '0;
      reply_q.delete();
      err_cnt    = 0;
      reply_cnt  = 0;
      commit_cnt = 0;
    end else begin
      // A reply never leaves in the cycle its beat is taken, so compare first.
      if (done_i) begin
        reply_cnt++;
        if (reply_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected reply beat: expected none, actual %h", $time, res_i);
        end else begin
          want = reply_q.pop_front();
          check_field("read_value", 64'(want.read_value), 64'(res_i.read_value));
          check_field("write_done", 64'(want.write_done), 64'(res_i.write_done));
          check_field("changed_offset", 64'(want.changed_offset),
                      64'(res_i.changed_offset));
          check_field("ready_res", 64'(want.ready_res), 64'(res_i.ready_res));
          check_field("active", 64'(want.active), 64'(res_i.active));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIZE_MODE:   size_large = cfg_wdata_i[0];
          CFG_BUSY_CYCLES: busy_len = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) reply_q.push_back(chip_step(req_i));
    end
    errors_o  <= err_cnt;
    pending_o <= reply_q.size();
    replies_o <= reply_cnt;
    commits_o <= commit_cnt;
  end

endmodule

FILE: test/serial_eeprom_bit_protocol_test.sv
`timescale 1ns / 1ps
// Top of the serial EEPROM bit protocol test: drives bus beats and chip settings
// into the block and gives the verdict. Depends on sebp_pkg, serial_eeprom_checker
// and the block itself.
module serial_eeprom_bit_protocol_test;
  import sebp_pkg::*;

  localparam int CHIP_SETTINGS = 6;
  localparam int PHASE_BEATS   = 320;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  req_t        req_i;
  logic        done_o;
  res_t        res_o;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [23:0] cfg_wdata_i;

  int mismatches;
  int pending;
  int replies;
  int commits;

  // Stimulus state.
  logic [63:0] bus_time;
  logic        cur_large;
  logic [23:0] cur_busy;
  logic [9:0]  hot_addr [8];
  req_t        burst_q [$];
  int          commit_at;
  logic        near_max;
  logic        wild_ok;
  int          gap_max;
  int          beats_sent;

  serial_eeprom_bit_protocol i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  serial_eeprom_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .done_i      (done_o),
    .res_i       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (mismatches),
    .pending_o   (pending),
    .replies_o   (replies),
    .commits_o   (commits)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] next_ts();
    bus_time = bus_time + 64'($urandom_range(0, 3));
    return bus_time;
  endfunction

  task automatic send_beat(input req_t beat);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= beat;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_clock(input req_type_e kind, input logic b, input logic ab,
                            input logic [63:0] ts);
    req_t beat;
    beat.req_type  = kind;
    beat.bit_in    = b;
    beat.abort     = ab;
    beat.timestamp = ts;
    send_beat(beat);
  endtask

  // Waits until every reply is back, then waits out the pipeline.
  task automatic drain_replies();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_chip(input logic big_chip, input logic [23:0] cycles);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SIZE_MODE;
    cfg_wdata_i <= {23'd0, big_chip};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BUSY_CYCLES;
    cfg_wdata_i <= cycles;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_large = big_chip;
    cur_busy  = cycles;
  endtask

  task automatic add_beat(input req_type_e kind, input logic b, input logic ab);
    req_t beat;
    beat.req_type  = kind;
    beat.bit_in    = b;
    beat.abort     = ab;
    beat.timestamp = '0;
    burst_q.push_back(beat);
  endtask

  function automatic logic [13:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return {4'($urandom), hot_addr[$urandom_range(0, 7)]};
      default: return 14'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One complete read or write transfer with random content.
  task automatic build_access(input logic rd);
    logic [13:0] addr;
    logic [63:0] word;
    int          alen;
    int          nreads;
    int          odd_at;
    burst_q.delete();
    commit_at = -1;
    near_max  = 1'b0;
    wild_ok   = 1'b0;
    alen = cur_large ? 14 : 6;
    addr = pick_addr();
    add_beat(REQ_WRITE, 1'b1, 1'($urandom));
    add_beat(REQ_WRITE, rd, 1'($urandom));
    for (int i = alen - 1; i >= 0; i--) add_beat(REQ_WRITE, addr[i], 1'($urandom));
    if (rd) begin
      add_beat(REQ_WRITE, 1'($urandom), 1'($urandom));
      // Deselect right at bit zero keeps the read unless it aborts.
      if ($urandom_range(0, 3) == 0) add_beat(REQ_DESEL, 1'($urandom), 1'($urandom));
      nreads = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 67) : 68;
      odd_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nreads - 1) : -1;
      for (int i = 0; i < nreads; i++) begin
        if (i == odd_at) add_beat(REQ_WRITE, 1'($urandom), 1'($urandom));
        add_beat(REQ_READ, 1'($urandom), 1'($urandom));
      end
    end else begin
      word = pick_word();
      hot_addr[$urandom_range(0, 7)] = cur_large ? addr[9:0] : {4'd0, addr[5:0]};
      for (int i = 63; i >= 0; i--) add_beat(REQ_WRITE, word[i], 1'($urandom));
      commit_at = burst_q.size();
      near_max  = ($urandom_range(0, 24) == 0);
      add_beat(REQ_WRITE, 1'($urandom), 1'($urandom));
    end
    add_beat(REQ_DESEL, 1'($urandom), 1'($urandom));
  endtask

  task automatic build_noise();
    burst_q.delete();
    commit_at = -1;
    near_max  = 1'b0;
    wild_ok   = 1'b1;
    repeat ($urandom_range(1, 5))
      add_beat(req_type_e'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
  endtask

  task automatic trim_burst();
    int keep;
    if (burst_q.size() > 1) begin
      keep = $urandom_range(1, burst_q.size() - 1);
      while (burst_q.size() > keep) void'(burst_q.pop_back());
      if (commit_at >= keep) commit_at = -1;
    end
  endtask

  task automatic send_burst();
    req_t b;
    int   k;
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
    for (int i = 0; i < burst_q.size(); i++) begin
      b = burst_q[i];
      if (i == commit_at && near_max)
        b.timestamp = ~64'd0 - 64'(cur_busy)
                      + ((cur_busy != 0) ? 64'($urandom_range(0, 1)) : 64'd0);
      else if (wild_ok && b.req_type != REQ_WRITE && $urandom_range(0, 3) == 0)
        b.timestamp = {$urandom, $urandom};
      else
        b.timestamp = next_ts();
      send_beat(b);
      if (i == commit_at) begin
        if (near_max) begin
          // A ready clock at the top of the count closes any window, then time restarts low.
          send_clock(REQ_READ, 1'($urandom), 1'($urandom), '1);
          bus_time = 64'($urandom);
        end else begin
          k = $urandom_range(0, 9);
          if (k < 7)
            bus_time = b.timestamp + 64'(cur_busy);
          else if (k < 9 && cur_busy >= 2)
            bus_time = b.timestamp + 64'(cur_busy) - 64'd2;
        end
      end
    end
  endtask

  initial begin
    int   pick;
    int   phase_start;
    int   k;
    req_t tmp;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_SIZE_MODE;
    cfg_wdata_i <= '0;
    bus_time   = '0;
    cur_large  = 1'b0;
    cur_busy   = BUSY_CYCLES_RESET;
    beats_sent = 0;
    gap_max    = 17;
    foreach (hot_addr[i]) hot_addr[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed pass over single clocks and protocol corners.
    send_clock(REQ_READ, 1'b0, 1'b0, 64'd0);
    send_clock(REQ_RSVD, 1'b1, 1'b1, '1);
    send_clock(REQ_DESEL, 1'b1, 1'b0, 64'd1);
    send_clock(REQ_DESEL, 1'b0, 1'b1, 64'd2);
    send_clock(REQ_WRITE, 1'b0, 1'b0, 64'd3);
    send_clock(REQ_WRITE, 1'b1, 1'b0, 64'd4);
    send_clock(REQ_WRITE, 1'b1, 1'b0, 64'd5);
    send_clock(REQ_DESEL, 1'b0, 1'b0, 64'd6);
    send_clock(REQ_READ, 1'b1, 1'b1, '1);
    send_clock(REQ_WRITE, 1'b1, 1'b1, 64'd7);
    send_clock(REQ_WRITE, 1'b0, 1'b1, 64'd8);
    send_clock(REQ_READ, 1'b0, 1'b0, 64'd9);
    send_clock(REQ_RSVD, 1'b0, 1'b0, 64'd10);
    send_clock(REQ_DESEL, 1'b0, 1'b1, 64'd11);
    bus_time = 64'd12;

    for (int ph = 0; ph < CHIP_SETTINGS; ph++) begin
      if (ph > 0) begin
        drain_replies();
        case (ph)
          1:       set_chip(1'b1, 24'd1);
          2:       set_chip(1'b0, 24'hFF_FFFF);
          3:       set_chip(1'b1, 24'd0);
          4:       set_chip(1'b0, 24'($urandom_range(2, 300)));
          default: set_chip(1'b1, 24'($urandom_range(1000, 200000)));
        endcase
      end
      // Step well past any window left open by the previous setting.
      bus_time = bus_time + (64'd1 << 25);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) build_noise();
        else build_access(pick >= 6);
        // The last burst of a setting is cut so the size change lands mid-transfer.
        if (beats_sent - phase_start + burst_q.size() >= PHASE_BEATS) begin
          trim_burst();
        end else if ($urandom_range(0, 9) == 0) begin
          trim_burst();
        end else if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, burst_q.size() - 1);
          tmp = burst_q[k];
          tmp.bit_in = ~tmp.bit_in;
          burst_q[k] = tmp;
        end
        send_burst();
        if ($urandom_range(0, 19) == 0) drain_replies();
      end
    end

    start_i <= 1'b0;
    for (int c = 0; c < 2000 && pending != 0; c++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending != 0) $display("%0d expected replies never arrived", pending);
    $display("Ran %0d bus beats over %0d chip settings, both address sizes,",
             beats_sent, CHIP_SETTINGS);
    $display("busy windows 0 to %0d; checked %0d reply beats, %0d words committed.",
             24'hFF_FFFF, replies, commits);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sebp_pkg.sv
rtl/sebp_store.sv
rtl/serial_eeprom_bit_protocol.sv
test/serial_eeprom_checker.sv
test/serial_eeprom_bit_protocol_test.sv
